[design/bfsp_pkg.sv]
// shared types, request codes and helpers for the bit field stream packer
package bfsp_pkg;

   localparam int DEF_MAX_WORDS = 256;

   localparam logic [2:0] REQ_WRITE      = 3'd0;
   localparam logic [2:0] REQ_READ       = 3'd1;
   localparam logic [2:0] REQ_FLUSH      = 3'd2;
   localparam logic [2:0] REQ_SEEK_BEGIN = 3'd3;
   localparam logic [2:0] REQ_SEEK_END   = 3'd4;
   localparam logic [2:0] REQ_CLEAR      = 3'd5;

   localparam logic [8:0] CFG_RESET_WORDS = 9'd256;

   typedef struct packed {
      logic [4:0]  bit_cursor;
      logic [8:0]  word_cursor;
      logic [13:0] bits_count;
      logic [8:0]  words_count;
      logic        overflow;
      logic [31:0] scratch_hi;
   } cursor_type;

   typedef struct packed {
      logic        wr_en;
      logic [8:0]  wr_word;
      logic [31:0] wr_data;
   } store_type;

   // capacity in use: register value clamped to 1..max_words
   function automatic logic [8:0] clamp_cap(logic [8:0] words, int max_words);
      if (words == 9'd0) begin
         return 9'd1;
      end
      if (32'(words) > 32'(max_words)) begin
         return 9'(max_words);
      end
      return words;
   endfunction

endpackage

[design/bfsp_word_mem.sv]
// single-port word store with registered read data
module bfsp_word_mem #(
   parameter int DEPTH = bfsp_pkg::DEF_MAX_WORDS,
   parameter int AW    = 8
) (
   input  logic          clock,
   input  logic          we,
   input  logic          re,
   input  logic [AW-1:0] addr,
   input  logic [31:0]   wdata,
   output logic [31:0]   rdata
);

   logic [31:0] store_ff [DEPTH];
   logic [31:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= store_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[design/bfsp_field_unit.sv]
// next-state and result logic for one request, given the fetched words
module bfsp_field_unit (
   input  logic [2:0]           req_type,
   input  logic [5:0]           field_width,
   input  logic [31:0]          write_value,
   input  bfsp_pkg::cursor_type cur,
   input  logic [8:0]           cap,
   input  logic [31:0]          word0_raw,
   input  logic [31:0]          word1_raw,
   output bfsp_pkg::cursor_type nxt,
   output bfsp_pkg::store_type  store,
   output logic [31:0]          read_value,
   output logic                 straddle
);

   logic        fits;
   logic [6:0]  sum;
   logic [13:0] limit;
   logic [14:0] bits_sum;
   logic        wc_in_cap;
   logic        wc1_in_cap;
   logic [8:0]  wc_next;
   logic [31:0] word0;
   logic [31:0] word1;
   logic [63:0] pair_sh;
   logic [63:0] mask;
   logic [6:0]  ins_sh;
   logic [63:0] ins;
   logic [63:0] full;
   logic        do_store;
   logic [31:0] store_data;

   assign fits       = field_width <= 6'd32;
   assign sum        = {2'b00, cur.bit_cursor} + {1'b0, field_width};
   assign limit      = {cap, 5'b00000};
   assign bits_sum   = {1'b0, cur.bits_count} + {9'd0, field_width};
   assign wc_in_cap  = cur.word_cursor < cap;
   assign wc_next    = cur.word_cursor + 9'd1;
   assign wc1_in_cap = wc_in_cap && (wc_next < cap);

   // words past capacity read as zero
   assign word0   = wc_in_cap  ? word0_raw : 32'd0;
   assign word1   = wc1_in_cap ? word1_raw : 32'd0;
   assign pair_sh = {word0, word1} << cur.bit_cursor;

   assign mask   = (64'd1 << field_width) - 64'd1;
   assign ins_sh = 7'd64 - {2'b00, cur.bit_cursor} - {1'b0, field_width};
   assign ins    = ({32'd0, write_value} & mask) << ins_sh;
   assign full   = {cur.scratch_hi, 32'd0} | ins;

   // a read that runs past the current word needs the next one
   assign straddle = (req_type == bfsp_pkg::REQ_READ) && fits && (sum > 7'd32);

   always_comb begin
      nxt        = cur;
      store      = '0;
      do_store   = 1'b0;
      store_data = cur.scratch_hi;
      read_value = 32'd0;
      case (req_type)
         bfsp_pkg::REQ_WRITE: begin
            if (fits) begin
               nxt.bit_cursor = sum[4:0];
               if (sum >= 7'd32) begin
                  do_store       = 1'b1;
                  store_data     = full[63:32];
                  nxt.scratch_hi = full[31:0];
               end else begin
                  nxt.scratch_hi = full[63:32];
               end
               nxt.bits_count = (bits_sum > {1'b0, limit}) ? limit : bits_sum[13:0];
            end
         end
         bfsp_pkg::REQ_READ: begin
            if (fits) begin
               nxt.bit_cursor = sum[4:0];
               if (sum >= 7'd32 && wc_in_cap) begin
                  nxt.word_cursor = wc_next;
               end
               if (field_width != 6'd0) begin
                  read_value = pair_sh[63:32] >> (6'd32 - field_width);
               end
            end
         end
         bfsp_pkg::REQ_FLUSH: begin
            do_store = cur.bit_cursor != 5'd0;
         end
         bfsp_pkg::REQ_SEEK_BEGIN: begin
            nxt.bit_cursor  = 5'd0;
            nxt.word_cursor = 9'd0;
         end
         bfsp_pkg::REQ_SEEK_END: begin
            nxt.bit_cursor  = cur.bits_count[4:0];
            nxt.word_cursor = cur.bits_count[13:5];
         end
         bfsp_pkg::REQ_CLEAR: begin
            nxt = '0;
         end
         default: begin
         end
      endcase

      // store the upper scratch word, or flag overflow when full
      if (do_store) begin
         if (!wc_in_cap) begin
            nxt.overflow = 1'b1;
         end else begin
            store.wr_en     = 1'b1;
            store.wr_word   = cur.word_cursor;
            store.wr_data   = store_data;
            nxt.word_cursor = wc_next;
            if (cur.words_count < cap) begin
               nxt.words_count = cur.words_count + 9'd1;
            end
         end
      end
   end

endmodule

[design/bit_field_stream_packer.sv]
// top level: request sequencer, cursor registers, word store and result register
//
// Packs fields of 0 to 32 bits, msb first, into a store of 32-bit words and
// reads them back from a shared cursor. Requests arrive on the req_ channel
// (valid/ready), one result beat per request leaves on the rsp_ channel.
// csr_buffer_words sets the number of words in use; write it while idle.
// A request accepted in IDLE is executed in EXEC from the fetched word and its
// result is registered. A read that straddles two words also passes through EXEC2,
// the second fetch going through the single memory port. A clear zeroes the
// words in use one per cycle in CLEAR, then gives its result.
// After reset every word of the store is swept to zero with req_ready
// low; csr writes are taken during the sweep.
// One result register sits on the output: a new request is taken while a
// result waits, and the next result holds in its last step until rsp_ready.
module bit_field_stream_packer #(
   parameter int MAX_WORDS = bfsp_pkg::DEF_MAX_WORDS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [5:0]  req_field_width,
   input  logic [31:0] req_write_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_value,
   output logic [13:0] rsp_total_bits,
   output logic [8:0]  rsp_total_words,
   output logic        rsp_overflow,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [8:0]  csr_buffer_words
);

   localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_EXEC  = 3'd2;
   localparam logic [2:0] ST_EXEC2 = 3'd3;
   localparam logic [2:0] ST_CLEAR = 3'd4;

   logic [2:0]           state_ff, state_in;
   bfsp_pkg::cursor_type cur_ff, cur_in;
   logic [8:0]           cap_ff, cap_in;
   logic [AW-1:0]        sweep_ff, sweep_in;
   logic [AW-1:0]        sweep_last_ff, sweep_last_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2:0]           req_type_ff, req_type_in;
   logic [5:0]           field_width_ff, field_width_in;
   logic [31:0]          write_value_ff, write_value_in;
   logic [31:0]          word0_ff, word0_in;
   logic [31:0]          rsp_read_value_ff, rsp_read_value_in;
   logic [13:0]          rsp_total_bits_ff, rsp_total_bits_in;
   logic [8:0]           rsp_total_words_ff, rsp_total_words_in;
   logic                 rsp_overflow_ff, rsp_overflow_in;

   logic                 mem_we;
   logic                 mem_re;
   logic [AW-1:0]        mem_addr;
   logic [31:0]          mem_wdata;
   logic [31:0]          mem_rdata;

   bfsp_pkg::cursor_type fu_nxt;
   bfsp_pkg::store_type  fu_store;
   logic [31:0]          fu_read_value;
   logic                 fu_straddle;
   logic [31:0]          fu_word0;
   logic                 out_free;
   logic                 commit;
   logic [8:0]           next_word;

   bfsp_word_mem #(
      .DEPTH (MAX_WORDS),
      .AW    (AW)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .re    (mem_re),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign fu_word0 = (state_ff == ST_EXEC2) ? word0_ff : mem_rdata;

   bfsp_field_unit u_field (
      .req_type    (req_type_ff),
      .field_width (field_width_ff),
      .write_value (write_value_ff),
      .cur         (cur_ff),
      .cap         (cap_ff),
      .word0_raw   (fu_word0),
      .word1_raw   (mem_rdata),
      .nxt         (fu_nxt),
      .store       (fu_store),
      .read_value  (fu_read_value),
      .straddle    (fu_straddle)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign next_word = cur_ff.word_cursor + 9'd1;
   assign commit    = out_free &&
                      ((state_ff == ST_EXEC && !fu_straddle &&
                        req_type_ff != bfsp_pkg::REQ_CLEAR) ||
                       state_ff == ST_EXEC2);

   always_comb begin
      state_in           = state_ff;
      cur_in             = cur_ff;
      cap_in             = cap_ff;
      sweep_in           = sweep_ff;
      sweep_last_in      = sweep_last_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      req_type_in        = req_type_ff;
      field_width_in     = field_width_ff;
      write_value_in     = write_value_ff;
      word0_in           = word0_ff;
      rsp_read_value_in  = rsp_read_value_ff;
      rsp_total_bits_in  = rsp_total_bits_ff;
      rsp_total_words_in = rsp_total_words_ff;
      rsp_overflow_in    = rsp_overflow_ff;
      mem_we             = 1'b0;
      mem_re             = 1'b0;
      mem_addr           = AW'(cur_ff.word_cursor);
      mem_wdata          = 32'd0;

      if (csr_valid) begin
         cap_in = bfsp_pkg::clamp_cap(csr_buffer_words, MAX_WORDS);
      end

      case (state_ff)
         ST_INIT: begin
            mem_we   = 1'b1;
            mem_addr = sweep_ff;
            if (sweep_ff == sweep_last_ff) begin
               state_in = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_type_in    = req_type;
               field_width_in = req_field_width;
               write_value_in = req_write_value;
               mem_re         = 1'b1;
               state_in       = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (fu_straddle) begin
               mem_re   = 1'b1;
               mem_addr = AW'(next_word);
               word0_in = mem_rdata;
               state_in = ST_EXEC2;
            end else if (req_type_ff == bfsp_pkg::REQ_CLEAR) begin
               cur_in        = fu_nxt;
               sweep_in      = '0;
               sweep_last_in = AW'(cap_ff - 9'd1);
               state_in      = ST_CLEAR;
            end
         end
         ST_EXEC2: begin
         end
         ST_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = sweep_ff;
            if (sweep_ff == sweep_last_ff) begin
               if (out_free) begin
                  rsp_valid_in       = 1'b1;
                  rsp_read_value_in  = 32'd0;
                  rsp_total_bits_in  = cur_ff.bits_count;
                  rsp_total_words_in = cur_ff.words_count;
                  rsp_overflow_in    = cur_ff.overflow;
                  state_in           = ST_IDLE;
               end
            end else begin
               sweep_in = sweep_ff + AW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (commit) begin
         cur_in             = fu_nxt;
         mem_we             = fu_store.wr_en;
         mem_addr           = AW'(fu_store.wr_word);
         mem_wdata          = fu_store.wr_data;
         rsp_valid_in       = 1'b1;
         rsp_read_value_in  = fu_read_value;
         rsp_total_bits_in  = fu_nxt.bits_count;
         rsp_total_words_in = fu_nxt.words_count;
         rsp_overflow_in    = fu_nxt.overflow;
         state_in           = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         cur_ff        <= '0;
         cap_ff        <= bfsp_pkg::clamp_cap(bfsp_pkg::CFG_RESET_WORDS, MAX_WORDS);
         sweep_ff      <= '0;
         sweep_last_ff <= AW'(MAX_WORDS - 1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_ff        <= cur_in;
         cap_ff        <= cap_in;
         sweep_ff      <= sweep_in;
         sweep_last_ff <= sweep_last_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_type_ff        <= req_type_in;
      field_width_ff     <= field_width_in;
      write_value_ff     <= write_value_in;
      word0_ff           <= word0_in;
      rsp_read_value_ff  <= rsp_read_value_in;
      rsp_total_bits_ff  <= rsp_total_bits_in;
      rsp_total_words_ff <= rsp_total_words_in;
      rsp_overflow_ff    <= rsp_overflow_in;
   end

   assign req_ready       = state_ff == ST_IDLE;
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_total_bits  = rsp_total_bits_ff;
   assign rsp_total_words = rsp_total_words_ff;
   assign rsp_overflow    = rsp_overflow_ff;

   // single memory port: never read and write in the same cycle
   a_mem_port: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("word store read and written in one cycle");

   // the second word fetch only follows a straddling read
   a_exec2_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXEC2 |-> req_type_ff == bfsp_pkg::REQ_READ)
      else $error("second fetch for a request that is not a read");

   // overflow is sticky until a clear
   a_overflow_sticky: assert property (@(posedge clock) disable iff (reset)
      cur_ff.overflow && !(state_ff == ST_EXEC && req_type_ff == bfsp_pkg::REQ_CLEAR)
      |=> cur_ff.overflow)
      else $error("overflow flag dropped without a clear");

   // a result beat is produced only when leaving a working state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff ##1 rsp_valid_ff |->
      ($past(state_ff) == ST_EXEC || $past(state_ff) == ST_EXEC2 ||
       $past(state_ff) == ST_CLEAR))
      else $error("result beat without a request in flight");

endmodule

[bench/tb_bit_field_stream_packer.sv]
// self-checking testbench for the bit field stream packer
`timescale 1ns / 1ps

module tb_bit_field_stream_packer;

   localparam int          STORE_WORDS = bfsp_pkg::DEF_MAX_WORDS;
   localparam logic [2:0]  REQ_RSVD6   = 3'd6;
   localparam logic [2:0]  REQ_RSVD7   = 3'd7;
   localparam int unsigned QUIET_LIMIT = 4000;
   localparam int unsigned TAIL_CYCLES = 20;

   typedef struct packed {
      logic [31:0] read_value;
      logic [13:0] total_bits;
      logic [8:0]  total_words;
      logic        overflow;
   } packer_result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_type;
   logic [5:0]  req_field_width;
   logic [31:0] req_write_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_read_value;
   logic [13:0] rsp_total_bits;
   logic [8:0]  rsp_total_words;
   logic        rsp_overflow;
   logic        csr_valid;
   logic        csr_ready;
   logic [8:0]  csr_buffer_words;

   bit_field_stream_packer #(.MAX_WORDS(STORE_WORDS)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_field_width (req_field_width),
      .req_write_value (req_write_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_value  (rsp_read_value),
      .rsp_total_bits  (rsp_total_bits),
      .rsp_total_words (rsp_total_words),
      .rsp_overflow    (rsp_overflow),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_buffer_words(csr_buffer_words)
   );

   // packer state as the bench sees it
   logic [31:0] store_copy [STORE_WORDS];
   logic [63:0] scratch_copy;
   int unsigned bit_pos;
   int unsigned word_pos;
   int unsigned bits_total;
   int unsigned words_total;
   logic        overflow_seen;
   logic [8:0]  buffer_words_set;

   packer_result_type results_due[$];
   int unsigned       send_idle_pct;
   int unsigned       recv_stall_pct;
   int unsigned       quiet_cycles;
   bit                failed;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned words_in_use();
      if (buffer_words_set == 9'd0) begin
         return 1;
      end
      if (buffer_words_set > STORE_WORDS) begin
         return STORE_WORDS;
      end
      return buffer_words_set;
   endfunction

   function automatic void commit_word();
      int unsigned cap;
      cap = words_in_use();
      if (word_pos >= cap) begin
         overflow_seen = 1'b1;
      end else begin
         store_copy[word_pos] = scratch_copy[63:32];
         word_pos++;
         if (words_total < cap) begin
            words_total++;
         end
      end
   endfunction

   function automatic packer_result_type pack_request(input logic [2:0]  kind,
                                                      input logic [5:0]  width,
                                                      input logic [31:0] value);
      int unsigned       cap;
      int unsigned       n;
      int unsigned       i;
      logic [31:0]       field;
      logic [31:0]       word;
      logic [63:0]       masked;
      packer_result_type res;
      cap   = words_in_use();
      n     = width;
      field = '0;
      case (kind)
         bfsp_pkg::REQ_WRITE: begin
            if (n <= 32) begin
               if (n > 0) begin
                  masked = {32'd0, value} & ((64'd1 << n) - 64'd1);
                  scratch_copy |= masked << (64 - bit_pos - n);
                  bit_pos += n;
               end
               if (bit_pos >= 32) begin
                  commit_word();
                  scratch_copy <<= 32;
                  bit_pos -= 32;
               end
               // clamp applies even to a zero-width write
               bits_total += n;
               if (bits_total > cap * 32) begin
                  bits_total = cap * 32;
               end
            end
         end
         bfsp_pkg::REQ_READ: begin
            if (n <= 32) begin
               for (i = 0; i < n; i++) begin
                  word  = (word_pos < cap) ? store_copy[word_pos] : 32'd0;
                  field = {field[30:0], word[31 - bit_pos]};
                  bit_pos++;
                  if (bit_pos >= 32) begin
                     bit_pos = 0;
                     if (word_pos < cap) begin
                        word_pos++;
                     end
                  end
               end
            end
         end
         bfsp_pkg::REQ_FLUSH: begin
            if (bit_pos != 0) begin
               commit_word();
            end
         end
         bfsp_pkg::REQ_SEEK_BEGIN: begin
            bit_pos  = 0;
            word_pos = 0;
         end
         bfsp_pkg::REQ_SEEK_END: begin
            bit_pos  = bits_total & 31;
            word_pos = bits_total >> 5;
         end
         bfsp_pkg::REQ_CLEAR: begin
            for (i = 0; i < cap; i++) begin
               store_copy[i] = '0;
            end
            scratch_copy  = '0;
            bit_pos       = 0;
            word_pos      = 0;
            bits_total    = 0;
            words_total   = 0;
            overflow_seen = 1'b0;
         end
         default: begin
         end
      endcase
      res.read_value  = field;
      res.total_bits  = 14'(bits_total);
      res.total_words = 9'(words_total);
      res.overflow    = overflow_seen;
      return res;
   endfunction

   // called at a falling edge, returns at the falling edge after the beat
   task automatic send_request(input logic [2:0] kind, input logic [5:0] width,
                               input logic [31:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid       = 1'b1;
      req_type        = kind;
      req_field_width = width;
      req_write_value = value;
      do @(posedge clock); while (!req_ready);
      results_due.push_back(pack_request(kind, width, value));
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid = 1'b0;
      while (results_due.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic set_buffer_words(input logic [8:0] words);
      drain_results();
      csr_buffer_words = words;
      csr_valid        = 1'b1;
      do @(posedge clock); while (!csr_ready);
      buffer_words_set = words;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic test_field_extremes();
      send_request(bfsp_pkg::REQ_WRITE, 6'd32, 32'hFFFF_FFFF);
      send_request(bfsp_pkg::REQ_WRITE, 6'd0, 32'hFFFF_FFFF);
      send_request(bfsp_pkg::REQ_WRITE, 6'd1, 32'hFFFF_FFFF);
      send_request(bfsp_pkg::REQ_WRITE, 6'd31, 32'h2AAA_AAAA);
      // too wide: nothing moves
      send_request(bfsp_pkg::REQ_WRITE, 6'd40, 32'hDEAD_BEEF);
      send_request(bfsp_pkg::REQ_WRITE, 6'd5, 32'hFFFF_FFF5);
      send_request(bfsp_pkg::REQ_FLUSH, 6'd0, 32'd0);
      send_request(bfsp_pkg::REQ_SEEK_BEGIN, 6'd0, 32'd0);
      send_request(bfsp_pkg::REQ_READ, 6'd32, 32'd0);
      send_request(bfsp_pkg::REQ_READ, 6'd0, 32'd0);
      send_request(bfsp_pkg::REQ_READ, 6'd17, 32'd0);
      // crosses into the next word
      send_request(bfsp_pkg::REQ_READ, 6'd20, 32'd0);
      send_request(bfsp_pkg::REQ_READ, 6'd63, 32'hFFFF_FFFF);
   endtask

   task automatic test_cursor_moves();
      send_request(bfsp_pkg::REQ_SEEK_END, 6'd0, 32'd0);
      send_request(bfsp_pkg::REQ_WRITE, 6'd12, 32'h5555_5ABC);
      send_request(REQ_RSVD6, 6'd5, 32'h1234_5678);
      send_request(REQ_RSVD7, 6'd63, 32'hFFFF_FFFF);
      send_request(bfsp_pkg::REQ_FLUSH, 6'd0, 32'd0);
      send_request(bfsp_pkg::REQ_CLEAR, 6'd0, 32'd0);
      send_request(bfsp_pkg::REQ_READ, 6'd32, 32'd0);
   endtask

   task automatic test_capacity_limits();
      set_buffer_words(9'd1);
      send_request(bfsp_pkg::REQ_WRITE, 6'd32, 32'hA5A5_5A5A);
      // store full: word dropped
      send_request(bfsp_pkg::REQ_WRITE, 6'd32, 32'h0F0F_F0F0);
      send_request(bfsp_pkg::REQ_WRITE, 6'd16, 32'h0000_BEEF);
      send_request(bfsp_pkg::REQ_FLUSH, 6'd0, 32'd0);
      send_request(bfsp_pkg::REQ_SEEK_BEGIN, 6'd0, 32'd0);
      send_request(bfsp_pkg::REQ_READ, 6'd32, 32'd0);
      send_request(bfsp_pkg::REQ_READ, 6'd32, 32'd0);
      set_buffer_words(9'd0);
      send_request(bfsp_pkg::REQ_WRITE, 6'd32, 32'h8000_0001);
      set_buffer_words(9'd511);
      send_request(bfsp_pkg::REQ_WRITE, 6'd32, 32'h7FFF_FFFE);
   endtask

   // records of fields packed then read back, with noise mixed in
   task automatic run_records(input int unsigned goal);
      int unsigned done_items;
      int unsigned count;
      int unsigned i;
      int unsigned pick;
      logic [2:0]  kind;
      logic [5:0]  width;
      logic [31:0] value;
      done_items = 0;
      while (done_items < goal) begin
         count = $urandom_range(2, 16);
         for (i = 0; i < 2 * count + 3; i++) begin
            if (i < count) begin
               kind = bfsp_pkg::REQ_WRITE;
            end else if (i == count) begin
               kind = ($urandom_range(1) != 0) ? bfsp_pkg::REQ_FLUSH : bfsp_pkg::REQ_WRITE;
            end else if (i == count + 1) begin
               kind = bfsp_pkg::REQ_SEEK_BEGIN;
            end else if (i < 2 * count + 2) begin
               kind = bfsp_pkg::REQ_READ;
            end else begin
               kind = bfsp_pkg::REQ_SEEK_END;
            end
            pick = $urandom_range(9);
            if (pick == 0) begin
               width = 6'd0;
            end else if (pick < 3) begin
               width = 6'd32;
            end else begin
               width = 6'($urandom_range(1, 31));
            end
            value = ($urandom_range(9) == 0) ? 32'hFFFF_FFFF : 32'($urandom());
            if ($urandom_range(99) < 10) begin
               kind  = 3'($urandom_range(7));
               width = 6'($urandom_range(63));
            end
            send_request(kind, width, value);
            if (!(kind == REQ_RSVD6 || kind == REQ_RSVD7 ||
                  ((kind == bfsp_pkg::REQ_WRITE || kind == bfsp_pkg::REQ_READ) &&
                   width > 6'd32))) begin
               done_items++;
            end
         end
      end
   endtask

   task automatic test_random_traffic(input int unsigned idle_pct,
                                      input int unsigned stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      set_buffer_words(9'($urandom_range(1, 8)));
      run_records(140);
      set_buffer_words(9'($urandom_range(9, 64)));
      run_records(140);
      set_buffer_words(bfsp_pkg::CFG_RESET_WORDS);
      run_records(140);
      set_buffer_words(9'($urandom_range(511)));
      run_records(140);
   endtask

   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      packer_result_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (results_due.size() == 0) begin
            $error("result beat with no request outstanding");
            failed = 1'b1;
         end else begin
            due = results_due.pop_front();
            if (rsp_read_value !== due.read_value) begin
               $error("read_value: expected %0h, got %0h", due.read_value, rsp_read_value);
               failed = 1'b1;
            end
            if (rsp_total_bits !== due.total_bits) begin
               $error("total_bits: expected %0d, got %0d", due.total_bits, rsp_total_bits);
               failed = 1'b1;
            end
            if (rsp_total_words !== due.total_words) begin
               $error("total_words: expected %0d, got %0d", due.total_words,
                      rsp_total_words);
               failed = 1'b1;
            end
            if (rsp_overflow !== due.overflow) begin
               $error("overflow: expected %0b, got %0b", due.overflow, rsp_overflow);
               failed = 1'b1;
            end
         end
      end
   end

   // no beat on any channel for too long means the block is hung
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** bit_field_stream_packer: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_type         = bfsp_pkg::REQ_WRITE;
      req_field_width  = '0;
      req_write_value  = '0;
      csr_valid        = 1'b0;
      csr_buffer_words = bfsp_pkg::CFG_RESET_WORDS;
      send_idle_pct    = 38;
      recv_stall_pct   = 64;
      for (int i = 0; i < STORE_WORDS; i++) begin
         store_copy[i] = '0;
      end
      scratch_copy     = '0;
      bit_pos          = 0;
      word_pos         = 0;
      bits_total       = 0;
      words_total      = 0;
      overflow_seen    = 1'b0;
      buffer_words_set = bfsp_pkg::CFG_RESET_WORDS;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_field_extremes();
      test_cursor_moves();
      test_capacity_limits();
      test_random_traffic(38, 64);
      test_random_traffic(64, 38);
      test_random_traffic(0, 0);

      drain_results();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (!failed && results_due.size() == 0) begin
         $display("** bit_field_stream_packer: PASSED **");
      end else begin
         $display("** bit_field_stream_packer: FAILED **");
      end
      $finish;
   end

endmodule
